// File: rtl/ptc_pkg.sv
package ptc_pkg;

    // configuration register indexes
    localparam int CFG_AW = 3;
    localparam logic [CFG_AW-1:0] CFG_T1_T2 = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_T3_P1 = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_P2_P3 = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_P4_P5 = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_P6_P7 = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_P8_P9 = 3'd5;

    // pipeline shape
    localparam int PRE_STAGES  = 11;
    localparam int DIV_STAGES  = 64;
    localparam int POST_STAGES = 5;
    localparam int NPIPE       = PRE_STAGES + DIV_STAGES + POST_STAGES;
    localparam int DIV_FIRST   = PRE_STAGES;
    localparam int POST_FIRST  = PRE_STAGES + DIV_STAGES;

    // divisor magnitude width, the divisor is a 64-bit value shifted down by 33
    localparam int DM_W = 31;

    // fixed constants of the compensation
    localparam logic signed [33:0] T_OFFSET  = 34'sd128000;
    localparam logic [20:0]        P_FULL    = 21'd1048576;
    localparam logic [63:0]        P_SCALE   = 64'd3125;
    localparam logic [63:0]        V1_OFFSET = 64'h0000_8000_0000_0000;

    // temperature results carried alongside the pressure work
    typedef struct packed {
        logic [31:0] centi;
        logic [31:0] fine;
        logic        dz;
    } side_t;

endpackage

// File: rtl/pressure_temperature_compensation.sv
// Pressure and temperature compensation of a barometric sensor.
// Input channel s_*: one transaction carries a raw temperature and a raw
// pressure reading. Output channel m_*: one transaction per input with the
// temperature in hundredths of a degree, the fine temperature, the pressure
// in pascals as Q24.8 and a valid flag (low when the divisor is zero, then
// the pressure is zero).
// Calibration is written through cfg_wr_en/cfg_addr/cfg_wr_data; the user
// must do so only while idle, the block does not enforce it. Throughput: one
// transaction per cycle while the skid register is empty. Pipeline: 11 stages
// of temperature and pressure polynomial, 64 stages of the one-bit-per-stage
// restoring divider, 5 stages of the final correction and the output register.
// Reset (aresetn low, synchronous) clears the pipeline valid bits, the output
// and skid valid flags and the calibration registers.
// When the receiver stalls, one more result lands in a skid register; then
// s_tready drops and the whole pipeline holds until the skid register drains.
module pressure_temperature_compensation
    import ptc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [31:0]       cfg_wr_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [39:0]       s_tdata,   // raw_temp[19:0], raw_press[39:20]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [95:0]       m_tdata,   // temp_centi[31:0], fine_temp[63:32], press_q24_8[95:64]
    output logic [0:0]        m_tuser    // valid_res[0]
);

    // calibration registers
    logic [31:0] cal0_reg, cal1_reg, cal2_reg, cal3_reg, cal4_reg, cal5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal0_reg <= '0;
            cal1_reg <= '0;
            cal2_reg <= '0;
            cal3_reg <= '0;
            cal4_reg <= '0;
            cal5_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_T1_T2: cal0_reg <= cfg_wr_data;
                CFG_T3_P1: cal1_reg <= cfg_wr_data;
                CFG_P2_P3: cal2_reg <= cfg_wr_data;
                CFG_P4_P5: cal3_reg <= cfg_wr_data;
                CFG_P6_P7: cal4_reg <= cfg_wr_data;
                CFG_P8_P9: cal5_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // coefficient fields
    logic [15:0]        t1, p1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

    assign t1 = cal0_reg[15:0];
    assign t2 = $signed(cal0_reg[31:16]);
    assign t3 = $signed(cal1_reg[15:0]);
    assign p1 = cal1_reg[31:16];
    assign p2 = $signed(cal2_reg[15:0]);
    assign p3 = $signed(cal2_reg[31:16]);
    assign p4 = $signed(cal3_reg[15:0]);
    assign p5 = $signed(cal3_reg[31:16]);
    assign p6 = $signed(cal4_reg[15:0]);
    assign p7 = $signed(cal4_reg[31:16]);
    assign p8 = $signed(cal5_reg[15:0]);
    assign p9 = $signed(cal5_reg[31:16]);

    // pipeline enable, held while the skid register is occupied
    logic              en;
    logic              skid_valid_reg;
    logic [NPIPE-1:0]  vld_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // input fields
    logic [19:0] in_rt, in_rp;
    assign in_rt = s_tdata[19:0];
    assign in_rp = s_tdata[39:20];

    // stage registers before the divider
    logic signed [17:0] st1_a_reg;
    logic signed [16:0] st1_c_reg;
    logic [19:0]        st1_rp_reg, st2_rp_reg, st3_rp_reg, st4_rp_reg, st5_rp_reg;
    logic [19:0]        st6_rp_reg, st7_rp_reg, st8_rp_reg;
    logic signed [31:0] st2_pa_reg, st2_cc_reg;
    logic signed [31:0] st3_tv1_reg, st3_m3_reg;
    logic signed [31:0] st4_fine_reg;
    logic signed [33:0] st5_x_reg;
    side_t              st5_side_reg, st6_side_reg, st7_side_reg, st8_side_reg;
    side_t              st9_side_reg, st10_side_reg, st11_side_reg;
    logic signed [63:0] st6_xx_reg, st6_xp5_reg, st6_xp2_reg;
    logic signed [63:0] st7_v2a_reg, st7_xxp3_reg, st7_v2b_reg;
    logic [63:0]        st7_xp2s_reg;
    logic [63:0]        st8_v2_reg, st8_v1a_reg;
    logic [63:0]        st9_v1s_reg, st9_num_reg;
    logic [63:0]        st10_m_reg, st10_n_reg;
    logic [63:0]        st11_nm_reg;
    logic [DM_W-1:0]    st11_dm_reg;
    logic               st11_neg_reg;

    // stage logic before the divider
    logic signed [31:0] st2_pa_next, st2_cc_next;
    logic signed [31:0] st3_ccs, st3_m3_next, st4_fine_next, st5_f5;
    logic signed [33:0] st5_x_next;
    logic signed [63:0] st6_xx_next, st6_xp5_next, st6_xp2_next;
    logic signed [63:0] st7_v2a_next, st7_xxp3_next;
    logic [63:0]        st7_v2b_next, st8_v1a_next;
    logic [20:0]        st9_pd;
    logic signed [63:0] st10_m_next;
    logic signed [30:0] st11_v1;
    logic [DM_W-1:0]    st11_dm_next;
    logic [63:0]        st11_nm_next;
    side_t              st5_side_next;

    always_comb begin
        st2_pa_next   = st1_a_reg * t2;
        st2_cc_next   = st1_c_reg * st1_c_reg;
        st3_ccs       = st2_cc_reg >>> 12;
        st3_m3_next   = st3_ccs * t3;
        st4_fine_next = st3_tv1_reg + (st3_m3_reg >>> 14);
        st5_f5        = st4_fine_reg * 32'sd5 + 32'sd128;
        st5_x_next    = {{2{st4_fine_reg[31]}}, st4_fine_reg} - T_OFFSET;
        st5_side_next.centi = 32'(st5_f5 >>> 8);
        st5_side_next.fine  = st4_fine_reg;
        st5_side_next.dz    = 1'b0;
        st6_xx_next   = st5_x_reg * st5_x_reg;
        st6_xp5_next  = st5_x_reg * p5;
        st6_xp2_next  = st5_x_reg * p2;
        st7_v2a_next  = st6_xx_reg * p6;
        st7_xxp3_next = st6_xx_reg * p3;
        st7_v2b_next  = {st6_xp5_reg[46:0], 17'b0} + {{13{p4[15]}}, p4, 35'b0};
        st8_v1a_next  = 64'(st7_xxp3_reg >>> 8) + st7_xp2s_reg;
        st9_pd        = P_FULL - {1'b0, st8_rp_reg};
        st10_m_next   = $signed(st9_v1s_reg) * $signed({1'b0, p1});
        st11_v1       = $signed(st10_m_reg[63:33]);
        st11_dm_next  = st11_v1[30] ? DM_W'(-st11_v1) : DM_W'(st11_v1);
        st11_nm_next  = st10_n_reg[63] ? -st10_n_reg : st10_n_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st1_a_reg   <= $signed({1'b0, in_rt[19:3]}) - $signed({1'b0, t1, 1'b0});
            st1_c_reg   <= $signed({1'b0, in_rt[19:4]}) - $signed({1'b0, t1});
            st1_rp_reg  <= in_rp;
            st2_pa_reg  <= st2_pa_next;
            st2_cc_reg  <= st2_cc_next;
            st2_rp_reg  <= st1_rp_reg;
            st3_tv1_reg <= st2_pa_reg >>> 11;
            st3_m3_reg  <= st3_m3_next;
            st3_rp_reg  <= st2_rp_reg;
            st4_fine_reg <= st4_fine_next;
            st4_rp_reg  <= st3_rp_reg;
            st5_x_reg   <= st5_x_next;
            st5_side_reg <= st5_side_next;
            st5_rp_reg  <= st4_rp_reg;
            st6_xx_reg  <= st6_xx_next;
            st6_xp5_reg <= st6_xp5_next;
            st6_xp2_reg <= st6_xp2_next;
            st6_side_reg <= st5_side_reg;
            st6_rp_reg  <= st5_rp_reg;
            st7_v2a_reg <= st7_v2a_next;
            st7_xxp3_reg <= st7_xxp3_next;
            st7_v2b_reg <= $signed(st7_v2b_next);
            st7_xp2s_reg <= {st6_xp2_reg[51:0], 12'b0};
            st7_side_reg <= st6_side_reg;
            st7_rp_reg  <= st6_rp_reg;
            st8_v2_reg  <= st7_v2a_reg + st7_v2b_reg;
            st8_v1a_reg <= st8_v1a_next;
            st8_side_reg <= st7_side_reg;
            st8_rp_reg  <= st7_rp_reg;
            st9_v1s_reg <= st8_v1a_reg + V1_OFFSET;
            st9_num_reg <= {12'b0, st9_pd, 31'b0} - st8_v2_reg;
            st9_side_reg <= st8_side_reg;
            st10_m_reg  <= st10_m_next;
            st10_n_reg  <= st9_num_reg * P_SCALE;
            st10_side_reg <= st9_side_reg;
            st11_nm_reg <= st11_nm_next;
            st11_dm_reg <= st11_dm_next;
            st11_neg_reg <= st10_n_reg[63] ^ st11_v1[30];
            st11_side_reg.centi <= st10_side_reg.centi;
            st11_side_reg.fine  <= st10_side_reg.fine;
            st11_side_reg.dz    <= (st11_v1 == 31'sd0);
        end
    end

    // restoring divider, one quotient bit per stage
    logic [DM_W-1:0] dv_rem_reg [DIV_STAGES];
    logic [63:0]     dv_nq_reg  [DIV_STAGES];
    logic [DM_W-1:0] dv_dm_reg  [DIV_STAGES];
    logic            dv_neg_reg [DIV_STAGES];
    side_t           dv_side_reg [DIV_STAGES];
    logic [DM_W-1:0] dv_rem_src [DIV_STAGES];
    logic [63:0]     dv_nq_src  [DIV_STAGES];
    logic [DM_W-1:0] dv_dm_src  [DIV_STAGES];
    logic            dv_neg_src [DIV_STAGES];
    side_t           dv_side_src [DIV_STAGES];
    logic [DM_W:0]   dv_trial   [DIV_STAGES];
    logic [DM_W:0]   dv_diff    [DIV_STAGES];
    logic            dv_ge      [DIV_STAGES];

    always_comb begin
        for (int i = 0; i < DIV_STAGES; i++) begin
            if (i == 0) begin
                dv_rem_src[i]  = '0;
                dv_nq_src[i]   = st11_nm_reg;
                dv_dm_src[i]   = st11_dm_reg;
                dv_neg_src[i]  = st11_neg_reg;
                dv_side_src[i] = st11_side_reg;
            end else begin
                dv_rem_src[i]  = dv_rem_reg[i-1];
                dv_nq_src[i]   = dv_nq_reg[i-1];
                dv_dm_src[i]   = dv_dm_reg[i-1];
                dv_neg_src[i]  = dv_neg_reg[i-1];
                dv_side_src[i] = dv_side_reg[i-1];
            end
            dv_trial[i] = {dv_rem_src[i], dv_nq_src[i][63]};
            dv_diff[i]  = dv_trial[i] - {1'b0, dv_dm_src[i]};
            dv_ge[i]    = (dv_trial[i] >= {1'b0, dv_dm_src[i]});
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < DIV_STAGES; i++) begin
                dv_rem_reg[i]  <= dv_ge[i] ? dv_diff[i][DM_W-1:0] : dv_trial[i][DM_W-1:0];
                dv_nq_reg[i]   <= {dv_nq_src[i][62:0], dv_ge[i]};
                dv_dm_reg[i]   <= dv_dm_src[i];
                dv_neg_reg[i]  <= dv_neg_src[i];
                dv_side_reg[i] <= dv_side_src[i];
            end
        end
    end

    // final correction stages
    logic [63:0]        pp1_p_reg, pp2_p_reg, pp3_p_reg, pp4_p_reg;
    logic [63:0]        pp2_ll_reg, pp3_qq_reg;
    logic [31:0]        pp2_hl_reg;
    logic signed [63:0] pp2_p8p_reg, pp3_p8p_reg, pp4_p8p_reg, pp4_p9qq_reg;
    logic [63:0]        pp5_s_reg;
    side_t              pp1_side_reg, pp2_side_reg, pp3_side_reg, pp4_side_reg, pp5_side_reg;
    logic [63:0]        pp2_q13, pp1_q;
    logic signed [63:0] pp2_p8p_next, pp4_p9qq_next;
    logic [31:0]        pp2_hl_next;
    logic [63:0]        pp2_ll_next, pp5_s_next;

    always_comb begin
        pp1_q         = dv_nq_reg[DIV_STAGES-1];
        pp2_q13       = 64'($signed(pp1_p_reg) >>> 13);
        pp2_ll_next   = {32'b0, pp2_q13[31:0]} * {32'b0, pp2_q13[31:0]};
        pp2_hl_next   = pp2_q13[63:32] * pp2_q13[31:0];
        pp2_p8p_next  = $signed(pp1_p_reg) * p8;
        pp4_p9qq_next = $signed(pp3_qq_reg) * p9;
        pp5_s_next    = pp4_p_reg + 64'(pp4_p9qq_reg >>> 25) + 64'(pp4_p8p_reg >>> 19);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pp1_p_reg    <= dv_neg_reg[DIV_STAGES-1] ? -pp1_q : pp1_q;
            pp1_side_reg <= dv_side_reg[DIV_STAGES-1];
            pp2_p_reg    <= pp1_p_reg;
            pp2_ll_reg   <= pp2_ll_next;
            pp2_hl_reg   <= pp2_hl_next;
            pp2_p8p_reg  <= pp2_p8p_next;
            pp2_side_reg <= pp1_side_reg;
            pp3_p_reg    <= pp2_p_reg;
            pp3_qq_reg   <= pp2_ll_reg + {pp2_hl_reg[30:0], 1'b0, 32'b0};
            pp3_p8p_reg  <= pp2_p8p_reg;
            pp3_side_reg <= pp2_side_reg;
            pp4_p_reg    <= pp3_p_reg;
            pp4_p9qq_reg <= pp4_p9qq_next;
            pp4_p8p_reg  <= pp3_p8p_reg;
            pp4_side_reg <= pp3_side_reg;
            pp5_s_reg    <= pp5_s_next;
            pp5_side_reg <= pp4_side_reg;
        end
    end

    // result assembly from the last stage
    logic [31:0] res_press;
    logic [95:0] res_data;
    logic        res_ok;

    always_comb begin
        res_ok    = !pp5_side_reg.dz;
        res_press = res_ok ? (pp5_s_reg[39:8] + {{12{p7[15]}}, p7, 4'b0}) : 32'd0;
        res_data  = {res_press, pp5_side_reg.fine, pp5_side_reg.centi};
    end

    // valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NPIPE-2:0], s_tvalid};
        end
    end

    // output register and skid register
    logic        out_valid_reg;
    logic [95:0] out_data_reg, skid_data_reg;
    logic        out_ok_reg, skid_ok_reg;
    logic        pop, push;

    assign pop  = out_valid_reg && m_tready;
    assign push = en && vld_reg[NPIPE-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                out_data_reg   <= skid_data_reg;
                out_ok_reg     <= skid_ok_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= res_data;
                out_ok_reg    <= res_ok;
            end else begin
                skid_valid_reg <= 1'b1;
                skid_data_reg  <= res_data;
                skid_ok_reg    <= res_ok;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_ok_reg;

    // checks
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result while the output is empty");

    a_stall_to_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && out_valid_reg && !m_tready) |=> skid_valid_reg)
        else $error("result lost while the receiver stalled");

    a_zero_div_press: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[95:64] == 32'd0))
        else $error("pressure nonzero on a zero divisor");

    a_drain_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && m_tready) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid register did not move to the output");

endmodule

// File: tb/ptc_checker.sv
`timescale 1ns / 100ps

module ptc_checker
    import ptc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [31:0]       cfg_wr_data,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [39:0]       s_tdata,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [95:0]       m_tdata,
    input  logic [0:0]        m_tuser,
    output int                fail_count,
    output int                pending,
    output int                checked
);

    typedef struct packed {
        logic [31:0] centi;
        logic [31:0] fine;
        logic [31:0] press;
        logic        ok;
    } reading_t;

    logic [31:0] cal [6];
    reading_t    expected_readings[$];

    function automatic logic [31:0] asr32(logic [31:0] x, int s);
        return $signed(x) >>> s;
    endfunction

    function automatic logic [63:0] asr64(logic [63:0] x, int s);
        return $signed(x) >>> s;
    endfunction

    function automatic logic [63:0] sx16(logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    // truncating signed divide done on magnitudes, min / -1 wraps
    function automatic logic [63:0] div_trunc(logic [63:0] n, logic [63:0] d);
        logic [63:0] nm;
        logic [63:0] dm;
        logic [63:0] q;
        nm = n[63] ? -n : n;
        dm = d[63] ? -d : d;
        q = nm / dm;
        return (n[63] != d[63]) ? -q : q;
    endfunction

    // integer compensation of one raw temperature and pressure pair
    function automatic reading_t compensate(logic [19:0] rt, logic [19:0] rp);
        reading_t    r;
        logic [31:0] t1, t2, t3, a, m, tv1, c, tv2, fine;
        logic [63:0] x, v1, v2, p, q, tmp;
        t1 = {16'd0, cal[CFG_T1_T2][15:0]};
        t2 = {{16{cal[CFG_T1_T2][31]}}, cal[CFG_T1_T2][31:16]};
        t3 = {{16{cal[CFG_T3_P1][15]}}, cal[CFG_T3_P1][15:0]};
        // temperature, 32-bit wrapping
        a = ({12'd0, rt} >> 3) - (t1 << 1);
        m = a * t2;
        tv1 = asr32(m, 11);
        c = ({12'd0, rt} >> 4) - t1;
        m = c * c;
        m = asr32(m, 12) * t3;
        tv2 = asr32(m, 14);
        fine = tv1 + tv2;
        m = fine * 32'd5 + 32'd128;
        r.centi = asr32(m, 8);
        r.fine = fine;
        // pressure, 64-bit wrapping
        x = {{32{fine[31]}}, fine} - 64'd128000;
        v2 = x * x * sx16(cal[CFG_P6_P7][15:0]);
        v2 = v2 + ((x * sx16(cal[CFG_P4_P5][31:16])) << 17);
        v2 = v2 + (sx16(cal[CFG_P4_P5][15:0]) << 35);
        tmp = x * x * sx16(cal[CFG_P2_P3][31:16]);
        v1 = asr64(tmp, 8) + ((x * sx16(cal[CFG_P2_P3][15:0])) << 12);
        tmp = ((64'd1 << 47) + v1) * {48'd0, cal[CFG_T3_P1][31:16]};
        v1 = asr64(tmp, 33);
        r.press = '0;
        r.ok = 1'b0;
        if (v1 != 0) begin
            p = 64'd1048576 - {44'd0, rp};
            tmp = ((p << 31) - v2) * 64'd3125;
            p = div_trunc(tmp, v1);
            q = asr64(p, 13);
            tmp = sx16(cal[CFG_P8_P9][31:16]) * q * q;
            v1 = asr64(tmp, 25);
            tmp = sx16(cal[CFG_P8_P9][15:0]) * p;
            v2 = asr64(tmp, 19);
            p = asr64(p + v1 + v2, 8) + (sx16(cal[CFG_P6_P7][31:16]) << 4);
            r.press = p[31:0];
            r.ok = 1'b1;
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $time, field, got, want);
        fail_count++;
    endtask

    assign pending = expected_readings.size();

    // track calibration, predict on input transactions, compare output ones
    always @(posedge aclk) begin
        reading_t want;
        if (!aresetn) begin
            foreach (cal[i]) cal[i] = '0;
            expected_readings.delete();
        end else begin
            if (cfg_wr_en && cfg_addr <= CFG_P8_P9)
                cal[cfg_addr] = cfg_wr_data;
            if (s_tvalid && s_tready)
                expected_readings.push_back(compensate(s_tdata[19:0], s_tdata[39:20]));
            if (m_tvalid && m_tready) begin
                if (expected_readings.size() == 0) begin
                    $display("[%0t] output transaction with nothing expected", $time);
                    fail_count++;
                end else begin
                    want = expected_readings.pop_front();
                    checked++;
                    if (m_tdata[31:0] !== want.centi)
                        report_mismatch("temp_centi", m_tdata[31:0], want.centi);
                    if (m_tdata[63:32] !== want.fine)
                        report_mismatch("fine_temp", m_tdata[63:32], want.fine);
                    if (m_tdata[95:64] !== want.press)
                        report_mismatch("press_q24_8", m_tdata[95:64], want.press);
                    if (m_tuser[0] !== want.ok)
                        report_mismatch("valid_res", {31'd0, m_tuser[0]}, {31'd0, want.ok});
                end
            end
        end
    end

endmodule

// File: tb/tb_pressure_temperature_compensation.sv
`timescale 1ns / 100ps

module tb_pressure_temperature_compensation;
    import ptc_pkg::*;

    logic              aclk;
    logic              aresetn;
    logic              cfg_wr_en;
    logic [CFG_AW-1:0] cfg_addr;
    logic [31:0]       cfg_wr_data;
    logic              s_tvalid;
    logic              s_tready;
    logic [39:0]       s_tdata;   // raw_temp[19:0], raw_press[39:20]
    logic              m_tvalid;
    logic              m_tready;
    logic [95:0]       m_tdata;   // temp_centi[31:0], fine_temp[63:32], press_q24_8[95:64]
    logic [0:0]        m_tuser;   // valid_res[0]

    int fail_count;
    int pending;
    int checked;
    int items_sent;
    int cal_sets;
    bit idling;
    int hold_reqs;
    int holds_done;

    pressure_temperature_compensation DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    ptc_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending(pending), .checked(checked)
    );

    // clock
    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // run limit
    initial begin
        #6_000_000;
        $display("timeout with %0d readings outstanding", pending);
        $display("== FAIL ==");
        $finish;
    end

    // receiver: random stall bursts while idling is set, one long hold on request
    initial begin
        m_tready = 1'b0;
        forever begin
            if (hold_reqs > holds_done) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
                holds_done++;
            end else if (idling && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    // loads all six calibration registers back to back
    task automatic load_cal(logic [31:0] r0, logic [31:0] r1, logic [31:0] r2,
                            logic [31:0] r3, logic [31:0] r4, logic [31:0] r5);
        logic [31:0] vals [6];
        vals = '{r0, r1, r2, r3, r4, r5};
        for (int i = 0; i < 6; i++) begin
            cfg_wr_en   <= 1'b1;
            cfg_addr    <= CFG_AW'(i);
            cfg_wr_data <= vals[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        cal_sets++;
    endtask

    task automatic send_reading(logic [19:0] rt, logic [19:0] rp);
        if (idling && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rp, rt};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // sender pauses until every result is back, then lets the pipe settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (NPIPE + 10) @(posedge aclk);
    endtask

    // typical sensor coefficients with optional jitter on t1 and p1
    task automatic load_typical_cal(bit jitter);
        logic [15:0] t1, p1;
        t1 = 16'd27504 + (jitter ? 16'($urandom_range(0, 4000)) - 16'd2000 : 16'd0);
        p1 = 16'd36477 + (jitter ? 16'($urandom_range(0, 4000)) - 16'd2000 : 16'd0);
        load_cal({16'sd26435, t1}, {p1, -16'sd1000}, {16'sd3024, -16'sd10685},
                 {16'sd140, 16'sd2855}, {16'sd15500, -16'sd7}, {16'sd6000, -16'sd14600});
    endtask

    task automatic random_readings(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) != 0)
                // realistic span of the converter
                send_reading(20'($urandom_range(400000, 600000)),
                             20'($urandom_range(250000, 450000)));
            else
                send_reading(20'($urandom), 20'($urandom));
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = '0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        items_sent  = 0;
        cal_sets    = 0;
        idling      = 1'b1;
        hold_reqs   = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset calibration: divisor is zero, so pressure is flagged invalid
        send_reading(20'h00000, 20'h00000);
        send_reading(20'hFFFFF, 20'hFFFFF);
        send_reading(20'hAAAAA, 20'h55555);
        drain();

        // typical coefficients, edge readings
        load_typical_cal(0);
        send_reading(20'd519888, 20'd415148);
        send_reading(20'h00000, 20'h00000);
        send_reading(20'hFFFFF, 20'hFFFFF);
        send_reading(20'h55555, 20'hAAAAA);
        send_reading(20'hAAAAA, 20'h55555);
        send_reading(20'h00000, 20'hFFFFF);
        send_reading(20'hFFFFF, 20'h00000);
        drain();

        // extreme coefficients: all ones, most negative, most positive
        load_cal('1, '1, '1, '1, '1, '1);
        send_reading(20'h00000, 20'h00000);
        send_reading(20'hFFFFF, 20'hFFFFF);
        send_reading(20'd519888, 20'd415148);
        drain();
        load_cal(32'h8000_8000, 32'h8000_8000, 32'h8000_8000,
                 32'h8000_8000, 32'h8000_8000, 32'h8000_8000);
        send_reading(20'h00000, 20'hFFFFF);
        send_reading(20'hFFFFF, 20'h00000);
        send_reading(20'd519888, 20'd415148);
        drain();
        load_cal(32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF,
                 32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF);
        send_reading(20'h00000, 20'h00000);
        send_reading(20'hFFFFF, 20'hFFFFF);
        send_reading(20'd519888, 20'd415148);
        drain();

        // typical coefficients while the receiver holds off, pipe fills up
        load_typical_cal(1);
        hold_reqs++;
        random_readings(200);
        drain();

        // fully random coefficient sets
        for (int k = 0; k < 5; k++) begin
            load_cal($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            random_readings(50);
            drain();
        end

        // last stretch at full rate, no idling on either side
        idling = 1'b0;
        load_typical_cal(1);
        random_readings(200);
        drain();

        $display("sent %0d readings under %0d calibration sets, %0d results compared",
                 items_sent, cal_sets, checked);
        $display("covered zero divisor, extreme coefficients, back pressure and full rate");
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: pressure_temperature_compensation.f
rtl/ptc_pkg.sv
rtl/pressure_temperature_compensation.sv
tb/ptc_checker.sv
tb/tb_pressure_temperature_compensation.sv
